[rtl/lrsg_pkg.sv]
// Package for the status ring gauge controller: sizes, command, mode and
// colour codes, register indexes and reset values.
// Has no dependencies; imported by led_ring_status_gauge_top.
`default_nettype none

package lrsg_pkg;

    // Ring size and field widths.
    localparam int PIXEL_COUNT = 16;
    localparam int TIME_W      = 32;
    localparam int FILL_W      = 17;
    localparam int MODE_W      = 3;
    localparam int REQ_W       = 2;
    localparam int LIT_W       = 5;
    localparam int COL_W       = 3;
    localparam int PERIOD_W    = 16;

    // Configuration port sizes.
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int IDX_W       = 2;

    // Lit count arithmetic: fill * PIXEL_COUNT + half, then drop 16 fraction bits.
    localparam int PIX_W       = $clog2(PIXEL_COUNT + 1);
    localparam int PROD_W      = FILL_W + PIX_W + 1;
    localparam int FRAC_W      = 16;
    localparam int N_W         = PROD_W - FRAC_W;

    localparam logic [FILL_W-1:0] FULL_Q16 = FILL_W'(65536);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DIRTY = 2'd3;

    // Display modes.
    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ACTIVE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HIT      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STALE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DOWN     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DISABLED = 3'd5;

    // Colours.
    localparam logic [COL_W-1:0] COL_BLACK  = 3'd0;
    localparam logic [COL_W-1:0] COL_GREEN  = 3'd1;
    localparam logic [COL_W-1:0] COL_RED    = 3'd2;
    localparam logic [COL_W-1:0] COL_WHITE  = 3'd3;
    localparam logic [COL_W-1:0] COL_ORANGE = 3'd4;

    // Register indexes (byte address = 4 * index).
    localparam logic [IDX_W-1:0] IDX_BLINK      = 2'd0;
    localparam logic [IDX_W-1:0] IDX_DOWN_BLINK = 2'd1;
    localparam logic [IDX_W-1:0] IDX_SHOW       = 2'd2;

    // Register reset values.
    localparam logic [PERIOD_W-1:0] BLINK_RST      = 16'd500;
    localparam logic [PERIOD_W-1:0] DOWN_BLINK_RST = 16'd500;
    localparam logic [PERIOD_W-1:0] SHOW_RST       = 16'd20;

endpackage

`default_nettype wire

[rtl/led_ring_status_gauge_top.sv]
// Status ring gauge controller: command handling, blink timers, expiry,
// rendering and show pacing, with an APB-style register port.
// Depends on lrsg_pkg.
`default_nettype none

// Takes one item per clock cycle. Set, clear and mark-dirty items only update
// the held display state and give no result; a tick item gives one result in
// the output register on the cycle after it is accepted. The whole update of
// an item is one pass of compare and add logic from the held state to the next
// state, so the only thing that holds back a new item is a tick result still
// waiting in the output register while the consumer is stalled. Configuration
// registers should be written only while no tick result is pending.
module led_ring_status_gauge_top
    import lrsg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // Configuration port.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready,

    // Input item channel.
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [REQ_W-1:0]     req_type,
    input  wire logic [TIME_W-1:0]    now_ms,
    input  wire logic [FILL_W-1:0]    fill_fraction,
    input  wire logic [MODE_W-1:0]    mode_code,
    input  wire logic                 down_flag,
    input  wire logic [TIME_W-1:0]    ttl_ms,

    // Result item channel.
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [LIT_W-1:0]     lit_count,
    output logic      [COL_W-1:0]     fill_colour,
    output logic                      show_strobe,
    output logic                      remote_active
);

    // Configuration registers.
    logic [PERIOD_W-1:0] blink_period_reg, blink_period_next;
    logic [PERIOD_W-1:0] down_period_reg, down_period_next;
    logic [PERIOD_W-1:0] show_period_reg, show_period_next;

    // Display state.
    logic                blink_on_reg, blink_on_next;
    logic [TIME_W-1:0]   last_blink_reg, last_blink_next;
    logic                down_blink_on_reg, down_blink_on_next;
    logic [TIME_W-1:0]   last_down_blink_reg, last_down_blink_next;
    logic                active_reg, active_next;
    logic                down_latched_reg, down_latched_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [TIME_W-1:0]   expiry_reg, expiry_next;
    logic                pending_reg, pending_next;
    logic [TIME_W-1:0]   last_show_reg, last_show_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [LIT_W-1:0]    lit_reg, lit_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic                strobe_reg, strobe_next;
    logic                remote_reg, remote_next;

    logic                in_accept;
    logic                cfg_write;
    logic [IDX_W-1:0]    cfg_idx;

    // Tick datapath intermediates.
    logic [TIME_W-1:0]   blink_diff;
    logic [TIME_W-1:0]   down_diff;
    logic [TIME_W-1:0]   expiry_diff;
    logic [TIME_W-1:0]   show_diff;
    logic [TIME_W-1:0]   ttl_eff;
    logic                is_down_pre;
    logic                expire_hit;
    logic                act1;
    logic                down1;
    logic [MODE_W-1:0]   mode1;
    logic [FILL_W-1:0]   fill1;
    logic                pend1;
    logic [PROD_W-1:0]   lit_prod;
    logic [N_W-1:0]      lit_raw;
    logic [N_W-1:0]      lit_capped;

    // Handshakes.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[PADDR_W-1:2];

    assign out_valid     = out_valid_reg;
    assign lit_count     = lit_reg;
    assign fill_colour   = col_reg;
    assign show_strobe   = strobe_reg;
    assign remote_active = remote_reg;

    // Register read data.
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            IDX_BLINK:      prdata = PDATA_W'(blink_period_reg);
            IDX_DOWN_BLINK: prdata = PDATA_W'(down_period_reg);
            IDX_SHOW:       prdata = PDATA_W'(show_period_reg);
            default:        prdata = '0;
        endcase
    end

    // Register writes; unknown indexes are ignored.
    always_comb
    begin
        blink_period_next = blink_period_reg;
        down_period_next  = down_period_reg;
        show_period_next  = show_period_reg;
        if (cfg_write)
        begin
            unique case (cfg_idx)
                IDX_BLINK:      blink_period_next = pwdata[PERIOD_W-1:0];
                IDX_DOWN_BLINK: down_period_next  = pwdata[PERIOD_W-1:0];
                IDX_SHOW:       show_period_next  = pwdata[PERIOD_W-1:0];
                default:        ;
            endcase
        end
    end

    // Time differences, all modulo 2^32.
    assign blink_diff  = now_ms - last_blink_reg;
    assign down_diff   = now_ms - last_down_blink_reg;
    assign expiry_diff = now_ms - expiry_reg;
    assign show_diff   = now_ms - last_show_reg;
    assign ttl_eff     = (ttl_ms == '0) ? TIME_W'(1) : ttl_ms;

    // Expiry: a display expires once now has reached a nonzero expiry time.
    assign is_down_pre = down_latched_reg || (mode_reg == MODE_DOWN);
    assign expire_hit  = active_reg && (expiry_reg != '0) && !expiry_diff[TIME_W-1];

    // Rounded lit count from the fill after the expiry step, capped at the ring size.
    assign lit_prod = PROD_W'(fill1) * PROD_W'(PIXEL_COUNT) + PROD_W'(32768);
    assign lit_raw  = lit_prod[PROD_W-1:FRAC_W];
    assign lit_capped = (lit_raw > N_W'(PIXEL_COUNT)) ? N_W'(PIXEL_COUNT) : lit_raw;

    // Per-item state update and result.
    always_comb
    begin
        blink_on_next       = blink_on_reg;
        last_blink_next     = last_blink_reg;
        down_blink_on_next  = down_blink_on_reg;
        last_down_blink_next = last_down_blink_reg;
        active_next         = active_reg;
        down_latched_next   = down_latched_reg;
        fill_next           = fill_reg;
        mode_next           = mode_reg;
        expiry_next         = expiry_reg;
        pending_next        = pending_reg;
        last_show_next      = last_show_reg;

        out_valid_next = out_valid_reg && !out_ready;
        lit_next       = lit_reg;
        col_next       = col_reg;
        strobe_next    = strobe_reg;
        remote_next    = remote_reg;

        // State after the expiry step of a tick.
        act1  = active_reg;
        down1 = down_latched_reg;
        mode1 = mode_reg;
        fill1 = fill_reg;
        pend1 = pending_reg || (blink_diff >= TIME_W'(blink_period_reg));

        if (expire_hit)
        begin
            pend1 = 1'b1;
            if (is_down_pre)
            begin
                // Down stays latched.
            end
            else if (mode_reg == MODE_HIT)
            begin
                mode1 = MODE_ACTIVE;
            end
            else
            begin
                act1  = 1'b0;
                down1 = 1'b0;
                fill1 = FULL_Q16;
                mode1 = MODE_IDLE;
            end
        end

        if (in_accept)
        begin
            unique case (req_type)
                REQ_SET:
                begin
                    active_next       = 1'b1;
                    down_latched_next = down_flag;
                    fill_next         = (fill_fraction > FULL_Q16) ? FULL_Q16 : fill_fraction;
                    mode_next         = mode_code;
                    expiry_next       = now_ms + ttl_eff;
                    pending_next      = 1'b1;
                end

                REQ_CLEAR:
                begin
                    active_next       = 1'b0;
                    down_latched_next = 1'b0;
                    fill_next         = FULL_Q16;
                    mode_next         = MODE_IDLE;
                    expiry_next       = '0;
                    pending_next      = 1'b1;
                end

                REQ_DIRTY:
                begin
                    pending_next = 1'b1;
                end

                REQ_TICK:
                begin
                    // Hit flash blink toggle.
                    if (blink_diff >= TIME_W'(blink_period_reg))
                    begin
                        last_blink_next = now_ms;
                        blink_on_next   = !blink_on_reg;
                    end

                    active_next       = act1;
                    down_latched_next = down1;
                    mode_next         = mode1;
                    fill_next         = fill1;
                    if (expire_hit)
                    begin
                        expiry_next = '0;
                    end

                    // Render.
                    if (!act1)
                    begin
                        lit_next = LIT_W'(PIXEL_COUNT);
                        col_next = COL_GREEN;
                    end
                    else if (mode1 == MODE_DISABLED)
                    begin
                        lit_next = '0;
                        col_next = COL_BLACK;
                    end
                    else if (down1 || (mode1 == MODE_DOWN))
                    begin
                        if (down_diff >= TIME_W'(down_period_reg))
                        begin
                            last_down_blink_next = now_ms;
                            down_blink_on_next   = !down_blink_on_reg;
                            pend1                = 1'b1;
                        end
                        lit_next = down_blink_on_next ? LIT_W'(PIXEL_COUNT) : '0;
                        col_next = down_blink_on_next ? COL_RED : COL_BLACK;
                    end
                    else
                    begin
                        lit_next = LIT_W'(lit_capped);
                        if (mode1 == MODE_HIT)
                        begin
                            col_next = blink_on_next ? COL_WHITE : COL_RED;
                        end
                        else if (mode1 == MODE_STALE)
                        begin
                            col_next = COL_ORANGE;
                        end
                        else
                        begin
                            col_next = COL_GREEN;
                        end
                    end

                    // Show pacing.
                    pending_next = pend1;
                    strobe_next  = 1'b0;
                    if (pend1 && (show_diff >= TIME_W'(show_period_reg)))
                    begin
                        last_show_next = now_ms;
                        pending_next   = 1'b0;
                        strobe_next    = 1'b1;
                    end

                    remote_next    = act1;
                    out_valid_next = 1'b1;
                end

                default:
                begin
                end
            endcase
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_period_reg    <= BLINK_RST;
            down_period_reg     <= DOWN_BLINK_RST;
            show_period_reg     <= SHOW_RST;
            blink_on_reg        <= 1'b0;
            last_blink_reg      <= '0;
            down_blink_on_reg   <= 1'b0;
            last_down_blink_reg <= '0;
            active_reg          <= 1'b0;
            down_latched_reg    <= 1'b0;
            fill_reg            <= FULL_Q16;
            mode_reg            <= MODE_IDLE;
            expiry_reg          <= '0;
            pending_reg         <= 1'b1;
            last_show_reg       <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            blink_period_reg    <= blink_period_next;
            down_period_reg     <= down_period_next;
            show_period_reg     <= show_period_next;
            blink_on_reg        <= blink_on_next;
            last_blink_reg      <= last_blink_next;
            down_blink_on_reg   <= down_blink_on_next;
            last_down_blink_reg <= last_down_blink_next;
            active_reg          <= active_next;
            down_latched_reg    <= down_latched_next;
            fill_reg            <= fill_next;
            mode_reg            <= mode_next;
            expiry_reg          <= expiry_next;
            pending_reg         <= pending_next;
            last_show_reg       <= last_show_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        lit_reg    <= lit_next;
        col_reg    <= col_next;
        strobe_reg <= strobe_next;
        remote_reg <= remote_next;
    end

endmodule

`default_nettype wire
